### design/tactile_contact_detector_defines.svh
// ----------------------------------------------------------------------------
// Tactile contact detector assertion macros
// Shared concurrent assertion forms, clocked on i_clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef TACTILE_CONTACT_DETECTOR_DEFINES_SVH
`define TACTILE_CONTACT_DETECTOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define TCD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define TCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tactile contact detector package
// Shared types, status codes, register map and reset values.
// ----------------------------------------------------------------------------
package tcd_pkg;

    // Item mode codes
    localparam logic MODE_START  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_RUNNING  = 3'd0,
        ST_FINGER_A = 3'd1,
        ST_FINGER_B = 3'd2,
        ST_TORQUE   = 3'd3,
        ST_TIMEOUT  = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

    // Register map: index is paddr[4:2]
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned IDX_W  = 3;
    localparam logic [IDX_W-1:0] REG_DETECT_FORCE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_RUN_TIMEOUT    = 3'd1;
    localparam logic [IDX_W-1:0] REG_TORQUE_LIMIT   = 3'd2;
    localparam logic [IDX_W-1:0] REG_COUNT_NEED     = 3'd3;
    localparam logic [IDX_W-1:0] REG_TORQUE_HOLD_MS = 3'd4;
    localparam logic [IDX_W-1:0] REG_MIN_POSITION   = 3'd5;

    // Register reset values
    localparam logic [15:0] RST_DETECT_FORCE   = 16'd100;
    localparam logic [31:0] RST_RUN_TIMEOUT    = 32'd10000;
    localparam logic [14:0] RST_TORQUE_LIMIT   = 15'd400;
    localparam logic [3:0]  RST_COUNT_NEED     = 4'd3;
    localparam logic [15:0] RST_TORQUE_HOLD_MS = 16'd1000;
    localparam logic [15:0] RST_MIN_POSITION   = 16'd100;

    // Detection counter saturation value
    localparam logic [4:0] COUNT_MAX = 5'd31;

    typedef struct packed {
        logic [15:0] detect_force;
        logic [31:0] run_timeout;
        logic [14:0] torque_limit;
        logic [3:0]  count_need;
        logic [15:0] torque_hold_ms;
        logic [15:0] min_position;
    } t_cfg;

    typedef struct packed {
        logic               mode;
        logic [31:0]        now_ms;
        logic signed [15:0] motor_torque;
        logic [15:0]        motor_position;
        logic [15:0]        force_a;
        logic [15:0]        force_b;
    } t_in_item;

endpackage

### design/tcd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tactile contact detector input channel
// Valid/ready channel carrying one start or sample item.
// ----------------------------------------------------------------------------
interface tcd_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [31:0]        now_ms;
    logic signed [15:0] motor_torque;
    logic [15:0]        motor_position;
    logic [15:0]        force_a;
    logic [15:0]        force_b;

    modport source (
        output valid, mode, now_ms, motor_torque, motor_position, force_a, force_b,
        input  ready
    );

    modport sink (
        input  valid, mode, now_ms, motor_torque, motor_position, force_a, force_b,
        output ready
    );
endinterface

### design/tcd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tactile contact detector result channel
// Valid/ready channel carrying one status result per item.
// ----------------------------------------------------------------------------
interface tcd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       finished;

    modport source (
        output valid, status, finished,
        input  ready
    );

    modport sink (
        input  valid, status, finished,
        output ready
    );
endinterface

### design/tactile_contact_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tactile contact detector
// Gripper contact decision from finger forces, position, torque and time.
//
//   channel   dir  handshake            payload
//   i_in      in   valid/ready          mode, now_ms, motor_torque,
//                                       motor_position, force_a, force_b
//   o_out     out  valid/ready          status, finished
//   cfg       in   APB psel/penable     paddr, pwdata, prdata (pready tied high)
//
// One item per cycle sustained while the result side keeps taking results; each
// result passes through the input register, then the result register.
// The ordered checks and state update sit in one stage between the registers.
// A stalled result register holds while the input register still takes one
// more item; the input side stalls only when both are full.
// Synchronous active-low reset clears run state and loads register defaults.
// ----------------------------------------------------------------------------
module tactile_contact_detector (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tcd_in_if.sink                     i_in,
    tcd_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tcd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import tcd_pkg::*;

    t_cfg       cfg;
    t_in_item   r_item;
    logic       r_in_valid;
    logic       r_out_valid;
    logic [2:0] r_out_status;
    logic       r_out_finished;
    logic       advance;
    logic       in_xfer;
    logic [2:0] ev_status;
    logic       ev_finished;

    tcd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tcd_eval u_eval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_item     (r_item),
        .i_cfg      (cfg),
        .o_status   (ev_status),
        .o_finished (ev_finished)
    );

    // Move the held item into the result register when that slot frees up
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_xfer    = i_in.valid && i_in.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.mode           <= i_in.mode;
            r_item.now_ms         <= i_in.now_ms;
            r_item.motor_torque   <= i_in.motor_torque;
            r_item.motor_position <= i_in.motor_position;
            r_item.force_a        <= i_in.force_a;
            r_item.force_b        <= i_in.force_b;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_status   <= ev_status;
            r_out_finished <= ev_finished;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.status   = r_out_status;
    assign o_out.finished = r_out_finished;

endmodule

### design/tcd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tactile contact detector configuration registers
// APB-style register file holding thresholds, limits and times.
// ----------------------------------------------------------------------------
module tcd_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tcd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output tcd_pkg::t_cfg             o_cfg
);
    import tcd_pkg::*;

    t_cfg             r_cfg;
    logic             wr_en;
    logic [IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    // Write the addressed register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.detect_force   <= RST_DETECT_FORCE;
            r_cfg.run_timeout    <= RST_RUN_TIMEOUT;
            r_cfg.torque_limit   <= RST_TORQUE_LIMIT;
            r_cfg.count_need     <= RST_COUNT_NEED;
            r_cfg.torque_hold_ms <= RST_TORQUE_HOLD_MS;
            r_cfg.min_position   <= RST_MIN_POSITION;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DETECT_FORCE:   r_cfg.detect_force   <= pwdata[15:0];
                REG_RUN_TIMEOUT:    r_cfg.run_timeout    <= pwdata;
                REG_TORQUE_LIMIT:   r_cfg.torque_limit   <= pwdata[14:0];
                REG_COUNT_NEED:     r_cfg.count_need     <= pwdata[3:0];
                REG_TORQUE_HOLD_MS: r_cfg.torque_hold_ms <= pwdata[15:0];
                REG_MIN_POSITION:   r_cfg.min_position   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (reg_idx)
            REG_DETECT_FORCE:   prdata = {16'd0, r_cfg.detect_force};
            REG_RUN_TIMEOUT:    prdata = r_cfg.run_timeout;
            REG_TORQUE_LIMIT:   prdata = {17'd0, r_cfg.torque_limit};
            REG_COUNT_NEED:     prdata = {28'd0, r_cfg.count_need};
            REG_TORQUE_HOLD_MS: prdata = {16'd0, r_cfg.torque_hold_ms};
            REG_MIN_POSITION:   prdata = {16'd0, r_cfg.min_position};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

### design/tcd_eval.sv
`timescale 1ns / 1ps
`include "tactile_contact_detector_defines.svh"
// ----------------------------------------------------------------------------
// Tactile contact detector evaluation
// Run state and the ordered checks that turn one item into a status.
// ----------------------------------------------------------------------------
module tcd_eval (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  tcd_pkg::t_in_item i_item,
    input  tcd_pkg::t_cfg     i_cfg,
    output logic [2:0]        o_status,
    output logic              o_finished
);
    import tcd_pkg::*;

    typedef struct packed {
        logic        detect;
        logic [4:0]  count;
        logic [15:0] last;
    } t_finger;

    // One finger update: above threshold, count up on a rising force, else down; detect on count
    function automatic t_finger finger_step(
        input logic [15:0] force_v,
        input logic [4:0]  count_v,
        input logic [15:0] last_v,
        input logic [15:0] thresh,
        input logic [3:0]  needed
    );
        t_finger res;
        logic [4:0] cnt;
        res.detect = 1'b0;
        res.count  = count_v;
        res.last   = last_v;
        if (force_v > thresh) begin
            if (force_v > last_v) begin
                cnt = (count_v == COUNT_MAX) ? COUNT_MAX : count_v + 5'd1;
            end else begin
                cnt = (count_v == 5'd0) ? 5'd0 : count_v - 5'd1;
            end
            res.count  = cnt;
            res.detect = (cnt > {1'b0, needed});
            if (!res.detect) begin
                res.last = force_v;
            end
        end
        return res;
    endfunction

    logic [31:0] r_start_time, n_start_time;
    logic [4:0]  r_count_a, n_count_a;
    logic [4:0]  r_count_b, n_count_b;
    logic [15:0] r_last_a, n_last_a;
    logic [15:0] r_last_b, n_last_b;
    logic        r_done, n_done;
    t_status     r_final, n_final;

    logic [31:0] elapsed;
    logic [15:0] torque_mag;
    logic        timeout_hit;
    logic        empty_hit;
    logic        torque_hit;
    t_finger     fa;
    t_finger     fb;
    t_status     st;

    logic        start_in;
    logic        held_sample;
    logic        counts_clear;

    // Check terms for the item in flight
    always_comb begin
        elapsed     = i_item.now_ms - r_start_time;
        torque_mag  = i_item.motor_torque[15] ? 16'(-i_item.motor_torque)
                                              : i_item.motor_torque;
        timeout_hit = elapsed > i_cfg.run_timeout;
        empty_hit   = i_item.motor_position < i_cfg.min_position;
        torque_hit  = (elapsed > {16'd0, i_cfg.torque_hold_ms}) &&
                      (torque_mag > {1'b0, i_cfg.torque_limit});
        fa = finger_step(i_item.force_a, r_count_a, r_last_a,
                         i_cfg.detect_force, i_cfg.count_need);
        fb = finger_step(i_item.force_b, r_count_b, r_last_b,
                         i_cfg.detect_force, i_cfg.count_need);
    end

    // Next run state: a start clears the run; otherwise the first check to fire wins
    always_comb begin
        n_start_time = r_start_time;
        n_count_a    = r_count_a;
        n_count_b    = r_count_b;
        n_last_a     = r_last_a;
        n_last_b     = r_last_b;
        n_done       = r_done;
        n_final      = r_final;
        st           = ST_RUNNING;
        if (i_advance) begin
            if (i_item.mode == MODE_START) begin
                n_start_time = i_item.now_ms;
                n_count_a    = 5'd0;
                n_count_b    = 5'd0;
                n_last_a     = 16'd0;
                n_last_b     = 16'd0;
                n_done       = 1'b0;
                n_final      = ST_RUNNING;
            end else if (!r_done) begin
                priority if (timeout_hit) begin
                    st = ST_TIMEOUT;
                end else if (empty_hit) begin
                    st = ST_EMPTY;
                end else begin
                    n_count_a = fa.count;
                    n_last_a  = fa.last;
                    if (fa.detect) begin
                        st = ST_FINGER_A;
                    end else begin
                        n_count_b = fb.count;
                        n_last_b  = fb.last;
                        if (fb.detect) begin
                            st = ST_FINGER_B;
                        end else if (torque_hit) begin
                            st = ST_TORQUE;
                        end
                    end
                end
                if (st != ST_RUNNING) begin
                    n_done  = 1'b1;
                    n_final = st;
                end
            end
        end
    end

    // Result follows the updated hold state
    assign o_status   = n_done ? n_final : ST_RUNNING;
    assign o_finished = n_done;

    // Hold run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_time <= 32'd0;
            r_count_a    <= 5'd0;
            r_count_b    <= 5'd0;
            r_last_a     <= 16'd0;
            r_last_b     <= 16'd0;
            r_done       <= 1'b0;
            r_final      <= ST_RUNNING;
        end else begin
            r_start_time <= n_start_time;
            r_count_a    <= n_count_a;
            r_count_b    <= n_count_b;
            r_last_a     <= n_last_a;
            r_last_b     <= n_last_b;
            r_done       <= n_done;
            r_final      <= n_final;
        end
    end

    // Terms for the checks below
    assign start_in     = i_advance && (i_item.mode == MODE_START);
    assign held_sample  = i_advance && (i_item.mode == MODE_SAMPLE) && r_done;
    assign counts_clear = (r_count_a == 5'd0) && (r_count_b == 5'd0);

    `TCD_ASSERT_SAME(a_done_has_code, r_done, r_final != ST_RUNNING, "held status is running")
    `TCD_ASSERT_NEXT(a_start_clears, start_in, !r_done && counts_clear, "start kept run state")
    `TCD_ASSERT_NEXT(a_final_holds, held_sample, r_done && $stable(r_final), "final status moved")
    `TCD_ASSERT_NEXT(a_counts_hold, held_sample, $stable({r_count_a, r_count_b}), "counts moved")

endmodule

### tb/sv/tcd_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tactile contact detector scoreboard
// Predicts the status result of every accepted item from a private copy of
// the registers and run state, and matches results against it in order.
// ----------------------------------------------------------------------------
package tcd_tb_pkg;
    import tcd_pkg::*;

    typedef struct packed {
        t_status status;
        logic    finished;
    } t_contact_result;

    class contact_scoreboard;
        t_cfg            regs;
        logic [31:0]     run_start;
        logic [4:0]      hits [2];
        logic [15:0]     prev_level [2];
        logic            held;
        t_status         held_status;
        t_contact_result awaiting [$];
        int              errors;

        function new();
            regs.detect_force   = RST_DETECT_FORCE;
            regs.run_timeout    = RST_RUN_TIMEOUT;
            regs.torque_limit   = RST_TORQUE_LIMIT;
            regs.count_need     = RST_COUNT_NEED;
            regs.torque_hold_ms = RST_TORQUE_HOLD_MS;
            regs.min_position   = RST_MIN_POSITION;
            run_start = '0;
            errors    = 0;
            clear_run();
        endfunction

        // Drop counters, last forces and any held final status
        function void clear_run();
            hits[0]       = '0;
            hits[1]       = '0;
            prev_level[0] = '0;
            prev_level[1] = '0;
            held          = 1'b0;
            held_status   = ST_RUNNING;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                REG_DETECT_FORCE:   regs.detect_force   = value[15:0];
                REG_RUN_TIMEOUT:    regs.run_timeout    = value;
                REG_TORQUE_LIMIT:   regs.torque_limit   = value[14:0];
                REG_COUNT_NEED:     regs.count_need     = value[3:0];
                REG_TORQUE_HOLD_MS: regs.torque_hold_ms = value[15:0];
                REG_MIN_POSITION:   regs.min_position   = value[15:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [IDX_W-1:0] idx);
            case (idx)
                REG_DETECT_FORCE:   return {16'h0, regs.detect_force};
                REG_RUN_TIMEOUT:    return regs.run_timeout;
                REG_TORQUE_LIMIT:   return {17'h0, regs.torque_limit};
                REG_COUNT_NEED:     return {28'h0, regs.count_need};
                REG_TORQUE_HOLD_MS: return {16'h0, regs.torque_hold_ms};
                REG_MIN_POSITION:   return {16'h0, regs.min_position};
                default:            return '0;
            endcase
        endfunction

        // Above threshold, count a finger up on a rising force, else down to a floor of zero;
        // the last force only follows while the finger has not detected
        function bit finger_step(int f, logic [15:0] level);
            if (level <= regs.detect_force) begin
                return 1'b0;
            end
            if (level > prev_level[f]) begin
                if (hits[f] != COUNT_MAX) begin
                    hits[f] = hits[f] + 5'd1;
                end
            end else if (hits[f] != 5'd0) begin
                hits[f] = hits[f] - 5'd1;
            end
            if (hits[f] > {1'b0, regs.count_need}) begin
                return 1'b1;
            end
            prev_level[f] = level;
            return 1'b0;
        endfunction

        function t_contact_result predict_status(t_in_item it);
            logic [31:0]     elapsed;
            logic [16:0]     magnitude;
            t_status         st;
            t_contact_result r;
            if (it.mode == MODE_START) begin
                run_start = it.now_ms;
                clear_run();
                r.status   = ST_RUNNING;
                r.finished = 1'b0;
                return r;
            end
            if (!held) begin
                elapsed   = it.now_ms - run_start;
                magnitude = it.motor_torque[15] ? 17'h10000 - {1'b0, it.motor_torque}
                                                : {1'b0, it.motor_torque};
                st = ST_RUNNING;
                // Checks in priority order; finger B is skipped once A detects
                if (elapsed > regs.run_timeout) begin
                    st = ST_TIMEOUT;
                end else if (it.motor_position < regs.min_position) begin
                    st = ST_EMPTY;
                end else if (finger_step(0, it.force_a)) begin
                    st = ST_FINGER_A;
                end else if (finger_step(1, it.force_b)) begin
                    st = ST_FINGER_B;
                end else if (elapsed > {16'h0, regs.torque_hold_ms} &&
                             magnitude > {2'b0, regs.torque_limit}) begin
                    st = ST_TORQUE;
                end
                if (st != ST_RUNNING) begin
                    held        = 1'b1;
                    held_status = st;
                end
            end
            r.status   = held ? held_status : ST_RUNNING;
            r.finished = held;
            return r;
        endfunction

        function void note_item(t_in_item it);
            awaiting.push_back(predict_status(it));
        endfunction

        function void check_result(logic [2:0] status, logic finished);
            t_contact_result want;
            if (awaiting.size() == 0) begin
                errors++;
                $display("%0t: unexpected result status=%0d finished=%0b",
                         $time, status, finished);
                return;
            end
            want = awaiting.pop_front();
            if (status !== want.status) begin
                errors++;
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, status);
            end
            if (finished !== want.finished) begin
                errors++;
                $display("%0t: finished mismatch: expected %0b, actual %0b",
                         $time, want.finished, finished);
            end
        endfunction

        function int pending();
            return awaiting.size();
        endfunction
    endclass

endpackage

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tactile contact detector testbench
// Drives directed and randomized detection runs through several register
// settings with random idling and long result stalls, and checks every
// status result against a predicted sequence.
// ----------------------------------------------------------------------------
module tb_top;
    import tcd_pkg::*;
    import tcd_tb_pkg::*;

    // Addresses past the register map, written to show they are ignored
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int PHASES          = 6;
    localparam int LONG_HOLD       = 300;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    tcd_in_if  in_if ();
    tcd_out_if out_if ();

    tactile_contact_detector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    contact_scoreboard board = new();

    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int holds_served;
    int hold_left;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side ready: random stalls, plus long hold-offs on request
    initial begin
        out_if.ready = 1'b0;
        holds_served = 0;
        hold_left    = 0;
        forever begin
            @(negedge i_clk);
            if (holds_served < hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready = 1'b0;
            end else begin
                out_if.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Check each result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready) begin
            board.check_result(out_if.status, out_if.finished);
        end
    end

    // Offer one item and hold it until the transfer; called at a falling edge
    task automatic offer_item(input logic md, input logic [31:0] now,
                              input logic signed [15:0] tq, input logic [15:0] pos,
                              input logic [15:0] fa, input logic [15:0] fb);
        t_in_item it;
        it.mode           = md;
        it.now_ms         = now;
        it.motor_torque   = tq;
        it.motor_position = pos;
        it.force_a        = fa;
        it.force_b        = fb;
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid          = 1'b1;
        in_if.mode           = it.mode;
        in_if.now_ms         = it.now_ms;
        in_if.motor_torque   = it.motor_torque;
        in_if.motor_position = it.motor_position;
        in_if.force_a        = it.force_a;
        in_if.force_b        = it.force_b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        board.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.write_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic reg_check(input logic [IDX_W-1:0] idx);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== board.reg_value(idx)) begin
            board.errors++;
            $display("%0t: register %0d readback: expected %0h, actual %0h",
                     $time, idx, board.reg_value(idx), prdata);
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Write every register with junk above its width, then read all back
    task automatic load_config(input t_cfg c, input logic [31:0] junk);
        reg_write(REG_DETECT_FORCE, {junk[31:16], c.detect_force});
        reg_write(REG_RUN_TIMEOUT, c.run_timeout);
        reg_write(REG_TORQUE_LIMIT, {junk[31:15], c.torque_limit});
        reg_write(REG_COUNT_NEED, {junk[31:4], c.count_need});
        reg_write(REG_TORQUE_HOLD_MS, {junk[31:16], c.torque_hold_ms});
        reg_write(REG_MIN_POSITION, {junk[31:16], c.min_position});
        reg_write(REG_SPARE_LO, junk);
        reg_write(REG_SPARE_HI, ~junk);
        for (int i = REG_DETECT_FORCE; i <= REG_MIN_POSITION; i++) begin
            reg_check(IDX_W'(i));
        end
    endtask

    // Stop offering until every predicted result has been seen
    task automatic wait_drained();
        in_if.valid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Next finger force: mostly rising, sometimes falling, flat or at or below threshold
    function automatic logic [15:0] next_level(input logic [15:0] lvl);
        int r;
        int v;
        r = $urandom_range(99);
        v = int'(lvl);
        if (r < 60) begin
            v = v + int'($urandom_range(300, 1));
        end else if (r < 75) begin
            v = v - int'($urandom_range(300));
        end else if (r >= 85) begin
            v = int'($urandom_range(board.regs.detect_force));
        end
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    // Detection runs with random content, plus some raw noise items
    task automatic random_items(input int target);
        int                 sent;
        int                 run_len;
        int                 r;
        logic [31:0]        clock_ms;
        logic [15:0]        lvl_a;
        logic [15:0]        lvl_b;
        logic [15:0]        pos;
        logic [15:0]        mag;
        logic signed [15:0] tq;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(99) < 8) begin
                offer_item(1'($urandom_range(1)), $urandom, 16'($urandom),
                           16'($urandom), 16'($urandom), 16'($urandom));
                sent++;
            end else begin
                clock_ms = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF - $urandom_range(2000)
                                                    : $urandom;
                offer_item(MODE_START, clock_ms, 16'sd0, 16'd0, 16'd0, 16'd0);
                sent++;
                lvl_a   = next_level(board.regs.detect_force);
                lvl_b   = next_level(board.regs.detect_force);
                run_len = $urandom_range(30, 3);
                repeat (run_len) begin
                    // Advance time: often a little, rarely a long jump
                    r = $urandom_range(99);
                    if (r >= 95) begin
                        clock_ms += $urandom;
                    end else if (r >= 85) begin
                        clock_ms += $urandom_range(3000);
                    end else if (r >= 15) begin
                        clock_ms += $urandom_range(300);
                    end
                    if (board.regs.min_position != 0 && $urandom_range(19) == 0) begin
                        pos = 16'($urandom_range(board.regs.min_position - 1));
                    end else begin
                        pos = 16'($urandom_range(65535, board.regs.min_position));
                    end
                    if ($urandom_range(4) == 0) begin
                        tq = 16'($urandom);
                    end else begin
                        mag = 16'($urandom_range(board.regs.torque_limit));
                        tq  = $urandom_range(1) ? -mag : mag;
                    end
                    lvl_a = next_level(lvl_a);
                    lvl_b = next_level(lvl_b);
                    offer_item(MODE_SAMPLE, clock_ms, tq, pos, lvl_a, lvl_b);
                    sent++;
                end
            end
        end
    endtask

    // Main sequence
    initial begin
        t_cfg setting;
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        in_if.valid          = 1'b0;
        in_if.mode           = MODE_START;
        in_if.now_ms         = '0;
        in_if.motor_torque   = '0;
        in_if.motor_position = '0;
        in_if.force_a        = '0;
        in_if.force_b        = '0;
        send_idle_pct        = 17;
        recv_stall_pct       = 78;
        hold_requests        = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Sample before any start runs from start time zero
        offer_item(MODE_SAMPLE, 32'd5, 16'sd0, 16'd200, 16'd0, 16'd0);
        // Start just before the time wraps; force at threshold; torque held off
        offer_item(MODE_START, 32'hFFFF_FF00, 16'sd0, 16'd0, 16'd0, 16'd0);
        offer_item(MODE_SAMPLE, 32'd10, 16'sh8000, 16'd65535, 16'd100, 16'd0);
        // Finger A: count up, down, floor at zero, then climb past the need
        offer_item(MODE_SAMPLE, 32'd20, 16'sd0, 16'd65535, 16'd200, 16'd0);
        offer_item(MODE_SAMPLE, 32'd30, 16'sd0, 16'd500, 16'd150, 16'd0);
        offer_item(MODE_SAMPLE, 32'd40, 16'sd0, 16'd500, 16'd150, 16'd0);
        offer_item(MODE_SAMPLE, 32'd50, 16'sd0, 16'd500, 16'd300, 16'd0);
        offer_item(MODE_SAMPLE, 32'd60, 16'sd0, 16'd500, 16'd400, 16'd0);
        offer_item(MODE_SAMPLE, 32'd70, 16'sd0, 16'd500, 16'd500, 16'd0);
        offer_item(MODE_SAMPLE, 32'd80, 16'sd0, 16'd500, 16'd600, 16'd0);
        // Final status holds against a sample that would otherwise fire
        offer_item(MODE_SAMPLE, 32'd90, 16'sd0, 16'd0, 16'd0, 16'd0);
        // Finger B detects
        offer_item(MODE_START, 32'd1000, 16'sd0, 16'd0, 16'd0, 16'd0);
        offer_item(MODE_SAMPLE, 32'd1001, 16'sh7FFF, 16'd500, 16'd0, 16'd101);
        offer_item(MODE_SAMPLE, 32'd1002, 16'sh7FFF, 16'd500, 16'd0, 16'd102);
        offer_item(MODE_SAMPLE, 32'd1003, 16'sh7FFF, 16'd500, 16'd0, 16'd103);
        offer_item(MODE_SAMPLE, 32'd1004, 16'sh7FFF, 16'd500, 16'd0, 16'd65535);
        // Torque: off at exactly the hold time, fires just after
        offer_item(MODE_START, 32'd0, 16'sd0, 16'd0, 16'd0, 16'd0);
        offer_item(MODE_SAMPLE, 32'd1000, 16'sh7FFF, 16'd500, 16'd0, 16'd0);
        offer_item(MODE_SAMPLE, 32'd1001, -16'sd401, 16'd500, 16'd0, 16'd0);
        // Timeout
        offer_item(MODE_START, 32'd0, 16'sd0, 16'd0, 16'd0, 16'd0);
        offer_item(MODE_SAMPLE, 32'd10001, 16'sd0, 16'd500, 16'd0, 16'd0);
        // Closed empty
        offer_item(MODE_START, 32'd50, 16'sd0, 16'd0, 16'd0, 16'd0);
        offer_item(MODE_SAMPLE, 32'd60, 16'sd0, 16'd99, 16'd0, 16'd0);
        // Every compare exactly at its limit: nothing fires
        offer_item(MODE_START, 32'd0, 16'sd0, 16'd0, 16'd0, 16'd0);
        offer_item(MODE_SAMPLE, 32'd10000, 16'sd400, 16'd100, 16'd100, 16'd100);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < 2) begin
                send_idle_pct  = 17;
                recv_stall_pct = 78;
            end else if (phase < 4) begin
                send_idle_pct  = 78;
                recv_stall_pct = 17;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            if (phase > 0) begin
                wait_drained();
                case (phase)
                    1: begin
                        setting.detect_force   = 16'd0;
                        setting.run_timeout    = 32'hFFFF_FFFF;
                        setting.torque_limit   = 15'd0;
                        setting.count_need     = 4'd15;
                        setting.torque_hold_ms = 16'hFFFF;
                        setting.min_position   = 16'd0;
                    end
                    2: begin
                        setting.detect_force   = 16'hFFFF;
                        setting.run_timeout    = 32'd0;
                        setting.torque_limit   = 15'h7FFF;
                        setting.count_need     = 4'd0;
                        setting.torque_hold_ms = 16'd0;
                        setting.min_position   = 16'hFFFF;
                    end
                    default: begin
                        setting.detect_force   = 16'($urandom_range(2000));
                        setting.run_timeout    = $urandom_range(20000, 500);
                        setting.torque_limit   = 15'($urandom_range(3000));
                        setting.count_need     = 4'($urandom_range(15));
                        setting.torque_hold_ms = 16'($urandom_range(5000));
                        setting.min_position   = 16'($urandom_range(2000));
                    end
                endcase
                load_config(setting, $urandom);
            end
            // Long result stall while items keep coming, to fill the block
            if (phase == 0 || phase == 4) begin
                hold_requests++;
            end
            random_items(ITEMS_PER_PHASE);
        end

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/tcd_pkg.sv
design/tcd_in_if.sv
design/tcd_out_if.sv
design/tcd_cfg_regs.sv
design/tcd_eval.sv
design/tactile_contact_detector.sv
tb/sv/tcd_scoreboard_pkg.sv
tb/sv/tb_top.sv
